@@ sv/twq_pkg.sv @@
`default_nettype none

package twq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KIND_W   = 2;
    localparam int ID_W     = 8;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 2;
    localparam int QCOUNT_W = 5;

    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] wake;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        entry_t   fresh;
    } cell_ctl_t;

    typedef struct packed {
        logic valid;
        logic is_tail;
    } cell_pos_t;

endpackage

`default_nettype wire

@@ sv/twq_req_if.sv @@
`default_nettype none

interface twq_req_if import twq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   proc_id;
    logic [TIME_W-1:0] delay;
    logic [TIME_W-1:0] now;

    modport source (output valid, kind, proc_id, delay, now, input ready);
    modport sink (input valid, kind, proc_id, delay, now, output ready);
endinterface

`default_nettype wire

@@ sv/twq_rsp_if.sv @@
`default_nettype none

interface twq_rsp_if import twq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     popped_id;
    logic                timer_write;
    logic [TIME_W-1:0]   timer_load;
    logic [QCOUNT_W-1:0] queue_count;

    modport source (output valid, status, popped_id, timer_write, timer_load, queue_count,
                    input ready);
    modport sink (input valid, status, popped_id, timer_write, timer_load, queue_count,
                  output ready);
endinterface

`default_nettype wire

@@ sv/timer_wakeup_queue.sv @@
// Sorted queue of sleeping process ids, ordered by wake time.
//
// Requests arrive on the req channel (kind, proc_id, delay, now) and each one
// produces exactly one result on the rsp channel (status, popped_id,
// timer_write, timer_load, queue_count). Both channels move a request when
// valid and ready are high at a rising edge of clk.
//
// The entries live in a row of cells. An add inserts in parallel: every cell
// compares its own wake time, and the cells after the insertion point take
// the new entry or their neighbor's entry; a pop shifts the row by one cell.
// An add or a pop goes through S_ADD or S_POP to S_RESULT, which loads the
// output register and raises rsp.valid; an add when full, a pop or remove
// when empty and an unused kind go straight to S_RESULT. A remove rotates the
// row once through the head cell, one entry per cycle. One request is worked
// on at a time; the next waits until the last is in the output register.
//
// Reset empties the queue; the cell contents are not cleared. When the
// receiver stalls, the result is held in the output register and the block
// finishes at most one further request before it waits for rsp.ready.
`default_nettype none

module timer_wakeup_queue import twq_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    twq_req_if.sink    req,
    twq_rsp_if.source  rsp
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_ADD    = 5'b00010,
        S_POP    = 5'b00100,
        S_SCAN   = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic                found_reg, found_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic [ID_W-1:0]     id_reg, id_next;
    logic [TIME_W-1:0]   wake_reg, wake_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [ID_W-1:0]     popped_reg, popped_next;
    logic                timer_en_reg, timer_en_next;

    logic [STATUS_W-1:0] out_status_reg;
    logic [ID_W-1:0]     out_popped_reg;
    logic                out_twrite_reg;
    logic [TIME_W-1:0]   out_tload_reg;
    logic [QCOUNT_W-1:0] out_count_reg;
    logic                out_load;

    entry_t              entries [CAPACITY];
    logic                le_vec  [CAPACITY];
    cell_ctl_t           ctl;
    logic                head_match;
    logic [TIME_W-1:0]   head_wake;

    assign head_match = !found_reg && (entries[0].id == id_reg);
    assign head_wake  = entries[0].wake;

    always_comb
    begin
        ctl.fresh.id   = id_reg;
        ctl.fresh.wake = wake_reg;
        unique case (state_reg)
            S_ADD:    ctl.op = CELL_INSERT;
            S_POP:    ctl.op = CELL_SHIFT;
            S_SCAN:   ctl.op = head_match ? CELL_SHIFT : CELL_ROTATE;
            default:  ctl.op = CELL_HOLD;
        endcase
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        cell_pos_t pos;
        entry_t    prev_entry;
        entry_t    next_entry;
        logic      le_prev;

        assign pos.valid   = (CNT_W'(i) < total_reg);
        assign pos.is_tail = (CNT_W'(i + 1) == total_reg);

        if (i == 0)
        begin : g_first
            assign prev_entry = ctl.fresh;
            assign le_prev    = 1'b1;
        end
        else
        begin : g_inner
            assign prev_entry = entries[i-1];
            assign le_prev    = le_vec[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_entry = entries[i];
        end
        else
        begin : g_body
            assign next_entry = entries[i+1];
        end

        twq_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .pos        (pos),
            .le_prev    (le_prev),
            .prev_entry (prev_entry),
            .next_entry (next_entry),
            .head_entry (entries[0]),
            .entry      (entries[i]),
            .le         (le_vec[i])
        );
    end

    assign req.ready = (state_reg == S_IDLE);
    assign out_load  = (state_reg == S_RESULT) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        state_next    = state_reg;
        total_next    = total_reg;
        rem_next      = rem_reg;
        found_next    = found_reg;
        id_next       = id_reg;
        wake_next     = wake_reg;
        now_next      = now_reg;
        status_next   = status_reg;
        popped_next   = popped_reg;
        timer_en_next = timer_en_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    id_next       = req.proc_id;
                    wake_next     = req.now + req.delay;
                    now_next      = req.now;
                    status_next   = STATUS_OK;
                    popped_next   = '0;
                    timer_en_next = 1'b0;
                    found_next    = 1'b0;
                    rem_next      = total_reg;
                    state_next    = S_RESULT;
                    case (req.kind)
                        KIND_ADD:
                        begin
                            if (total_reg == CNT_W'(CAPACITY))
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                timer_en_next = 1'b1;
                                state_next    = S_ADD;
                            end
                        end
                        KIND_POP:
                        begin
                            if (total_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                timer_en_next = 1'b1;
                                state_next    = S_POP;
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (total_reg == '0)
                            begin
                                status_next = STATUS_NOT_FOUND;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                total_next = total_reg + CNT_W'(1);
                state_next = S_RESULT;
            end
            S_POP:
            begin
                popped_next = entries[0].id;
                total_next  = total_reg - CNT_W'(1);
                state_next  = S_RESULT;
            end
            S_SCAN:
            begin
                if (head_match)
                begin
                    total_next = total_reg - CNT_W'(1);
                    found_next = 1'b1;
                end
                rem_next = rem_reg - CNT_W'(1);
                if (rem_reg == CNT_W'(1))
                begin
                    status_next = (found_reg || head_match) ? STATUS_OK : STATUS_NOT_FOUND;
                    state_next  = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rsp_valid_next = out_load ? 1'b1 : (rsp_valid_reg && !rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            rem_reg       <= '0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            rem_reg       <= rem_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg       <= id_next;
        wake_reg     <= wake_next;
        now_reg      <= now_next;
        status_reg   <= status_next;
        popped_reg   <= popped_next;
        timer_en_reg <= timer_en_next;
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_popped_reg <= popped_reg;
            out_twrite_reg <= timer_en_reg && (total_reg != '0);
            out_count_reg  <= QCOUNT_W'(total_reg);
            if (timer_en_reg && (total_reg != '0) && (head_wake > now_reg))
            begin
                out_tload_reg <= head_wake - now_reg;
            end
            else
            begin
                out_tload_reg <= '0;
            end
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.popped_id   = out_popped_reg;
    assign rsp.timer_write = out_twrite_reg;
    assign rsp.timer_load  = out_tload_reg;
    assign rsp.queue_count = out_count_reg;

endmodule

`default_nettype wire

@@ sv/twq_cell.sv @@
`default_nettype none

module twq_cell import twq_pkg::*;
(
    input  wire logic      clk,
    input  wire cell_ctl_t ctl,
    input  wire cell_pos_t pos,
    input  wire logic      le_prev,
    input  wire entry_t    prev_entry,
    input  wire entry_t    next_entry,
    input  wire entry_t    head_entry,
    output entry_t         entry,
    output logic           le
);

    entry_t entry_reg;
    entry_t entry_next;

    // A valid cell is "at or before" the new entry when it holds a wake time no later than it.
    assign le    = pos.valid && (entry_reg.wake <= ctl.fresh.wake);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        case (ctl.op)
            CELL_INSERT:
            begin
                if (!le)
                begin
                    entry_next = le_prev ? ctl.fresh : prev_entry;
                end
            end
            CELL_SHIFT:
            begin
                entry_next = next_entry;
            end
            CELL_ROTATE:
            begin
                entry_next = pos.is_tail ? head_entry : next_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

@@ sv/twq_checker.sv @@
`default_nettype none

module twq_checker import twq_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                rsp_valid,
    input wire logic                rsp_ready,
    input wire logic [STATUS_W-1:0] status,
    input wire logic [ID_W-1:0]     popped_id,
    input wire logic                timer_write,
    input wire logic [TIME_W-1:0]   timer_load,
    input wire logic [QCOUNT_W-1:0] queue_count
);

    // A reload is only issued by a request that succeeded.
    a_timer_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && timer_write) |-> (status == STATUS_OK))
        else $error("timer reload issued with a failing status");

    // An empty queue has nothing to pop and nothing to time.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == STATUS_EMPTY))
        |-> ((queue_count == '0) && (popped_id == '0) && !timer_write))
        else $error("empty result carries data");

    // Without a reload the load value stays zero.
    a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !timer_write) |-> (timer_load == '0))
        else $error("timer load set without timer write");

    // A stalled result holds still.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready)
        |=> (rsp_valid && $stable(status) && $stable(popped_id) && $stable(timer_load)
             && $stable(queue_count)))
        else $error("stalled result changed");

endmodule

bind timer_wakeup_queue twq_checker u_twq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .popped_id   (rsp.popped_id),
    .timer_write (rsp.timer_write),
    .timer_load  (rsp.timer_load),
    .queue_count (rsp.queue_count)
);

`default_nettype wire
